@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the spectrum level scaler. They sample on
// clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SBLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbls assertion failed");

`define SBLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbls assertion failed");

`else

`define SBLS_ASSERT_IMP(lbl, ante, cons)

`define SBLS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/sbls_pkg.sv @@
// ----------------------------------------------------------------------------
// Spectrum level scaler package
// Register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sbls_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_MULT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_DIV = 1'b1;

  localparam logic [7:0] AVG_MULT_RESET = 8'd3;
  localparam logic [8:0] AVG_DIV_RESET = 9'd4;
  localparam logic [31:0] PEAK_AT_RESET = 32'd1000;
  localparam logic [15:0] MAX_LEVEL = 16'd255;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SQ_I  = 11'b000_0000_0010,
    ST_SQ_Q  = 11'b000_0000_0100,
    ST_MUL_A = 11'b000_0000_1000,
    ST_CHK1  = 11'b000_0001_0000,
    ST_DIV1  = 11'b000_0010_0000,
    ST_PEAK  = 11'b000_0100_0000,
    ST_MUL_L = 11'b000_1000_0000,
    ST_CHK2  = 11'b001_0000_0000,
    ST_DIV2  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

endpackage

`default_nettype wire

@@ hdl/spectrum_bin_level_scaler.sv @@
// ----------------------------------------------------------------------------
// Spectrum bin level scaler
// Turns FFT bins into waterfall display levels with a running average and
// per-frame peak normalization.
// ----------------------------------------------------------------------------
// The input channel carries one bin (action low, in_phase, quadrature) or an
// end-of-frame marker (action high) per transfer. Every input transfer yields
// exactly one transfer on the output channel carrying level.
// A bin runs through one shared 32x16 multiplier for I*I, Q*Q, the average
// weighting and the 255 scaling, and through one shared subtract-compare unit
// for two restoring divisions: 32 quotient steps by the average divisor and
// 8 steps by the previous frame's peak, each after a saturation check.
// A bin steps through SQ_I, SQ_Q, MUL_A, CHK1, DIV1, PEAK, MUL_L, CHK2 and DIV2
// to DONE, where a saturating check skips its division; an end-of-frame marker
// goes from idle straight to DONE. in_ready is high only while the sequencer
// is idle, so one item is worked on at a time: the next item is accepted
// once the last is in the output register. A finished level waits in the
// output register while the next item is already accepted; if the receiver
// stalls, the sequencer holds its next result until the output register is
// free. The configuration channel is always ready and should be used while
// idle. Reset clears the running average and frame peak, sets the scale peak
// to 1000 and the registers to multiplier 3 and divisor 4.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bin_level_scaler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sbls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbls_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            action,
  input  wire logic signed [15:0]              in_phase,
  input  wire logic signed [15:0]              quadrature,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           level
);

  import sbls_pkg::*;

  `include "assert_macros.svh"

  state_t      state;
  logic [7:0]  avg_mult;
  logic [8:0]  avg_div;
  logic [31:0] avg;
  logic [31:0] scale_peak;
  logic [31:0] frame_peak;
  logic [15:0] i_r;
  logic [15:0] q_r;
  logic [40:0] acc;
  logic [31:0] rem;
  logic [31:0] quot;
  logic [4:0]  cnt;

  logic [15:0] mag_i;
  logic [15:0] mag_q;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [40:0] acc_sum;
  logic [8:0]  div_eff;
  logic [31:0] dvsr;
  logic        shift_en;
  logic [32:0] opnd;
  logic [33:0] diff;
  logic        ge;

  assign mag_i = i_r[15] ? (~i_r + 16'd1) : i_r;
  assign mag_q = q_r[15] ? (~q_r + 16'd1) : q_r;

  always_comb begin
    case (state)
      ST_SQ_I: begin
        mul_a = {16'd0, mag_i};
        mul_b = mag_i;
      end
      ST_SQ_Q: begin
        mul_a = {16'd0, mag_q};
        mul_b = mag_q;
      end
      ST_MUL_A: begin
        mul_a = avg;
        mul_b = {8'd0, avg_mult};
      end
      ST_MUL_L: begin
        mul_a = avg;
        mul_b = MAX_LEVEL;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 16'd0;
      end
    endcase
  end

  assign prod = 48'(mul_a) * 48'(mul_b);
  assign acc_sum = acc + prod[40:0];

  assign div_eff = (avg_div == 9'd0) ? 9'd1 : avg_div;
  assign dvsr = (state == ST_CHK1 || state == ST_DIV1) ? {23'd0, div_eff} : scale_peak;
  assign shift_en = (state == ST_DIV1 || state == ST_DIV2);
  assign opnd = shift_en ? {rem, quot[31]} : {1'b0, rem};
  assign diff = {1'b0, opnd} - {2'b00, dvsr};
  assign ge = ~diff[33];

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      avg        <= 32'd0;
      scale_peak <= PEAK_AT_RESET;
      frame_peak <= 32'd0;
      avg_mult   <= AVG_MULT_RESET;
      avg_div    <= AVG_DIV_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_AVG_MULT: avg_mult <= cfg_data[7:0];
          CFG_AVG_DIV:  avg_div <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (action) begin
              scale_peak <= (frame_peak == 32'd0) ? 32'd1 : frame_peak;
              frame_peak <= 32'd0;
              quot       <= 32'd0;
              state      <= ST_DONE;
            end else begin
              i_r   <= in_phase;
              q_r   <= quadrature;
              state <= ST_SQ_I;
            end
          end
        end
        ST_SQ_I: begin
          acc   <= prod[40:0];
          state <= ST_SQ_Q;
        end
        ST_SQ_Q: begin
          acc   <= acc_sum;
          state <= ST_MUL_A;
        end
        ST_MUL_A: begin
          rem   <= {23'd0, acc_sum[40:32]};
          quot  <= acc_sum[31:0];
          state <= ST_CHK1;
        end
        ST_CHK1: begin
          cnt <= 5'd31;
          if (ge) begin
            quot  <= '1;
            state <= ST_PEAK;
          end else begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1, ST_DIV2: begin
          rem  <= ge ? diff[31:0] : opnd[31:0];
          quot <= {quot[30:0], ge};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= (state == ST_DIV1) ? ST_PEAK : ST_DONE;
          end
        end
        ST_PEAK: begin
          avg <= quot;
          if (frame_peak < quot) begin
            frame_peak <= quot;
          end
          state <= ST_MUL_L;
        end
        ST_MUL_L: begin
          rem   <= prod[39:8];
          quot  <= {prod[7:0], 24'd0};
          state <= ST_CHK2;
        end
        ST_CHK2: begin
          cnt <= 5'd7;
          if (ge) begin
            quot[7:0] <= 8'hFF;
            state     <= ST_DONE;
          end else begin
            state <= ST_DIV2;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            level <= quot[7:0];
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SBLS_ASSERT_NEXT(a_eof_clears_peak, in_valid && in_ready && action, frame_peak == 32'd0 && state == ST_DONE)
  `SBLS_ASSERT_IMP(a_scale_peak_nonzero, 1'b1, scale_peak != 32'd0)
  `SBLS_ASSERT_IMP(a_div_rem_below, shift_en, rem < dvsr)
  `SBLS_ASSERT_NEXT(a_peak_tracks_avg, state == ST_PEAK, frame_peak >= avg)

endmodule

`default_nettype wire
